FILE: rtl/lc3_pkg.sv
// Shared types, constants and opcodes for the LC-3 step core.
package lc3_pkg;

  localparam int unsigned MemDepth   = 65536;
  localparam logic [15:0] StartPcRst = 16'h3000;
  localparam logic [15:0] KbsrAddr   = 16'hFE00;
  localparam logic [7:0]  HaltVector = 8'h25;
  localparam logic [2:0]  FlagP      = 3'b001;
  localparam logic [2:0]  FlagZ      = 3'b010;
  localparam logic [2:0]  FlagN      = 3'b100;

  localparam logic [3:0] OpBr   = 4'h0;
  localparam logic [3:0] OpAdd  = 4'h1;
  localparam logic [3:0] OpLd   = 4'h2;
  localparam logic [3:0] OpSt   = 4'h3;
  localparam logic [3:0] OpJsr  = 4'h4;
  localparam logic [3:0] OpAnd  = 4'h5;
  localparam logic [3:0] OpLdr  = 4'h6;
  localparam logic [3:0] OpStr  = 4'h7;
  localparam logic [3:0] OpNot  = 4'h9;
  localparam logic [3:0] OpLdi  = 4'hA;
  localparam logic [3:0] OpSti  = 4'hB;
  localparam logic [3:0] OpJmp  = 4'hC;
  localparam logic [3:0] OpLea  = 4'hE;
  localparam logic [3:0] OpTrap = 4'hF;

  typedef struct packed {
    logic        command;
    logic [15:0] load_address;
    logic [15:0] load_data;
  } lc3_in_t;

  typedef struct packed {
    logic [15:0] pc_after;
    logic [2:0]  cond_flags;
    logic        halted;
    logic [15:0] executed_instruction;
    logic        trap_taken;
    logic [7:0]  trap_vector;
    logic        mem_written;
    logic [15:0] write_address;
    logic [15:0] write_data;
  } lc3_out_t;

  // memory address source chosen by the controller
  typedef enum logic [2:0] {
    ASEL_PC   = 3'd0,
    ASEL_OFF9 = 3'd1,
    ASEL_OFF6 = 3'd2,
    ASEL_MDR  = 3'd3,
    ASEL_LOAD = 3'd4
  } lc3_asel_e;

  typedef struct packed {
    logic      clr_run;     // clearing sweep in progress
    logic      latch_in;    // capture input word
    logic      mem_rd;      // read memory at selected address
    lc3_asel_e asel;
    logic      load_wr;     // write load word
    logic      latch_ir;    // mdr into instruction register
    logic      execute;     // run the instruction, using mdr as load data
    logic      emit;        // drive result strobe
  } lc3_cmd_t;

  typedef struct packed {
    logic       clr_done;
    logic       command;
    logic       running;
    logic [3:0] opcode;
  } lc3_stat_t;

  function automatic logic [15:0] sext(input logic [15:0] v, input int unsigned bits);
    logic [15:0] m;
    m = 16'((32'd1 << bits) - 32'd1);
    sext = v[bits-1] ? (v | ~m) : (v & m);
  endfunction

  function automatic logic [2:0] flags_of(input logic [15:0] v);
    flags_of = (v == 16'd0) ? FlagZ : (v[15] ? FlagN : FlagP);
  endfunction

endpackage

FILE: rtl/lc3_ram.sv
// Generic single-port RAM with registered read.
module lc3_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

FILE: rtl/lc3_ctrl.sv
// Step sequencer for the LC-3 core.
module lc3_ctrl import lc3_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  lc3_stat_t stat_i,
  output lc3_cmd_t  cmd_o
);
  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_DISP  = 9'b000000100,
    S_FETCH = 9'b000001000,
    S_DEC   = 9'b000010000,
    S_RD1   = 9'b000100000,
    S_RD2   = 9'b001000000,
    S_EXEC  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.asel = ASEL_PC;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_run = 1'b1;
        if (stat_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.latch_in = 1'b1;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        if (!stat_i.command) begin
          cmd_o.load_wr = 1'b1;
          cmd_o.asel = ASEL_LOAD;
          state_d = S_DONE;
        end else if (!stat_i.running) begin
          state_d = S_DONE;
        end else begin
          cmd_o.mem_rd = 1'b1;
          cmd_o.asel = ASEL_PC;
          state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd_o.latch_ir = 1'b1;
        state_d = S_DEC;
      end
      S_DEC: begin
        state_d = S_EXEC;
        if (stat_i.opcode == OpLd || stat_i.opcode == OpLdi || stat_i.opcode == OpSti) begin
          cmd_o.mem_rd = 1'b1;
          cmd_o.asel = ASEL_OFF9;
          state_d = (stat_i.opcode == OpLd) ? S_RD2 : S_RD1;
        end else if (stat_i.opcode == OpLdr) begin
          cmd_o.mem_rd = 1'b1;
          cmd_o.asel = ASEL_OFF6;
          state_d = S_RD2;
        end
      end
      S_RD1: begin
        // pointer word now in mdr
        if (stat_i.opcode == OpLdi) begin
          cmd_o.mem_rd = 1'b1;
          cmd_o.asel = ASEL_MDR;
          state_d = S_RD2;
        end else begin
          state_d = S_EXEC;
        end
      end
      S_RD2: state_d = S_EXEC;
      S_EXEC: begin
        cmd_o.execute = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        cmd_o.emit = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  assign busy = (state_q != S_IDLE);

  a_emit_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> state_q == S_IDLE) else $error("emit not followed by idle");
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clr_run |-> !cmd_o.latch_in) else $error("accept during clear");
  a_exec_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.execute |=> cmd_o.emit) else $error("execute without emit");
endmodule

FILE: rtl/lc3_dp.sv
// Datapath of the LC-3 core: registers, memory port, execute logic.
module lc3_dp import lc3_pkg::*; #(
  parameter int unsigned MemDepthP = MemDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  lc3_in_t     in_word_i,
  input  lc3_cmd_t    cmd_i,
  output lc3_stat_t   stat_o,
  output lc3_out_t    result_o
);
  localparam int unsigned Aw = $clog2(MemDepthP);

  logic [15:0] pc_q, pc_d;
  logic [2:0]  cc_q, cc_d;
  logic        run_q, run_d;
  logic [15:0] gpr_q [8];
  logic [15:0] ir_q;
  lc3_in_t     in_q;
  logic [Aw:0] clr_q;
  logic        rd_pend_q;
  logic [Aw-1:0] rd_addr_q;
  logic [15:0] mdr_q;
  lc3_out_t    res_q, res_d;

  logic          ram_we;
  logic [Aw-1:0] ram_addr;
  logic [15:0]   ram_wdata, ram_rdata, mdr;
  logic [15:0]   addr_sel;
  logic          kbsr_hit;

  logic [15:0] a, b, off9, off6, sr_val, new_pc;
  logic [3:0]  op;
  logic [2:0]  dr;

  logic [15:0] res_gpr;
  logic [15:0] rd_data;

  assign op   = ir_q[15:12];
  assign dr   = ir_q[11:9];
  assign a    = gpr_q[ir_q[8:6]];
  assign b    = ir_q[5] ? sext(ir_q, 5) : gpr_q[ir_q[2:0]];
  assign off9 = pc_q + sext(ir_q, 9);
  assign off6 = a + sext(ir_q, 6);
  assign sr_val = gpr_q[dr];

  // latest read data; reads of the keyboard status word come back as zero
  assign mdr = rd_pend_q ? rd_data : mdr_q;

  always_comb begin
    unique case (cmd_i.asel)
      ASEL_PC:   addr_sel = pc_q;
      ASEL_OFF9: addr_sel = off9;
      ASEL_OFF6: addr_sel = off6;
      ASEL_MDR:  addr_sel = mdr;
      ASEL_LOAD: addr_sel = in_q.load_address;
      default:   addr_sel = pc_q;
    endcase
  end

  assign kbsr_hit = cmd_i.mem_rd && (addr_sel == KbsrAddr);

  logic        st_wr;
  logic [15:0] st_addr;
  always_comb begin
    st_wr = cmd_i.execute && (op == OpSt || op == OpStr || op == OpSti);
    unique case (op)
      OpSt:    st_addr = off9;
      OpStr:   st_addr = off6;
      default: st_addr = mdr;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = addr_sel[Aw-1:0];
    ram_wdata = 16'd0;
    if (cmd_i.clr_run) begin
      ram_we   = 1'b1;
      ram_addr = clr_q[Aw-1:0];
    end else if (cmd_i.load_wr) begin
      ram_we    = 1'b1;
      ram_wdata = in_q.load_data;
    end else if (kbsr_hit) begin
      ram_we = 1'b1;   // clear on read, read-first returns old: mask below
    end else if (st_wr) begin
      ram_we    = 1'b1;
      ram_addr  = st_addr[Aw-1:0];
      ram_wdata = sr_val;
    end
  end

  lc3_ram #(.Width(16), .Depth(MemDepthP)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= '0;
      rd_pend_q <= 1'b0;
      pc_q      <= StartPcRst;
      cc_q      <= FlagZ;
      run_q     <= 1'b1;
      for (int i = 0; i < 8; i++) gpr_q[i] <= 16'd0;
    end else begin
      if (cmd_i.clr_run) clr_q <= clr_q + 1'b1;
      rd_pend_q <= cmd_i.mem_rd;
      pc_q  <= pc_d;
      cc_q  <= cc_d;
      run_q <= run_d;
      if (cmd_i.execute) begin
        if (op == OpAdd || op == OpAnd || op == OpNot || op == OpLd ||
            op == OpLdi || op == OpLdr || op == OpLea) begin
          gpr_q[dr] <= res_gpr;
        end else if (op == OpJsr) begin
          gpr_q[7] <= pc_q;
        end
      end
    end
  end

  assign rd_data = (rd_addr_q == KbsrAddr[Aw-1:0]) ? 16'd0 : ram_rdata;

  always_comb begin
    unique case (op)
      OpAdd:   res_gpr = a + b;
      OpAnd:   res_gpr = a & b;
      OpNot:   res_gpr = ~a;
      OpLea:   res_gpr = off9;
      default: res_gpr = mdr;
    endcase
  end

  always_comb begin
    pc_d  = pc_q;
    cc_d  = cc_q;
    run_d = run_q;
    new_pc = pc_q;
    if (cfg_we_i) begin
      pc_d = cfg_wdata_i;
    end else if (cmd_i.latch_ir) begin
      pc_d = pc_q + 16'd1;
    end else if (cmd_i.execute) begin
      unique case (op)
        OpBr:  if ((dr & cc_q) != 3'd0) new_pc = off9;
        OpJsr: new_pc = ir_q[11] ? pc_q + sext(ir_q, 11) : a;
        OpJmp: new_pc = a;
        OpTrap: if (ir_q[7:0] == HaltVector) run_d = 1'b0;
        default: new_pc = pc_q;
      endcase
      pc_d = new_pc;
      if (op == OpAdd || op == OpAnd || op == OpNot || op == OpLd ||
          op == OpLdi || op == OpLdr || op == OpLea) begin
        cc_d = flags_of(res_gpr);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_rd) rd_addr_q <= addr_sel[Aw-1:0];
    if (rd_pend_q) mdr_q <= rd_data;
    if (cmd_i.latch_in) in_q <= in_word_i;
    if (cmd_i.latch_ir) ir_q <= mdr;
    if (cmd_i.latch_in) ir_q <= 16'd0;
    res_q <= res_d;
  end

  always_comb begin
    res_d = res_q;
    if (cmd_i.load_wr) begin
      res_d = '0;
      res_d.mem_written   = 1'b1;
      res_d.write_address = in_q.load_address;
      res_d.write_data    = in_q.load_data;
    end else if (cmd_i.execute) begin
      res_d = '0;
      res_d.trap_taken  = (op == OpTrap);
      res_d.trap_vector = (op == OpTrap) ? ir_q[7:0] : 8'd0;
      res_d.mem_written = st_wr;
      res_d.write_address = st_wr ? st_addr : 16'd0;
      res_d.write_data    = st_wr ? sr_val : 16'd0;
    end else if (cmd_i.latch_in) begin
      res_d = '0;
    end
  end

  always_comb begin
    result_o = res_q;
    result_o.pc_after   = pc_q;
    result_o.cond_flags = cc_q;
    result_o.halted     = !run_q;
    result_o.executed_instruction = ir_q;
  end

  assign stat_o.clr_done = (clr_q == (Aw+1)'(MemDepthP - 1));
  assign stat_o.command  = in_q.command;
  assign stat_o.running  = run_q;
  assign stat_o.opcode   = op;
endmodule

FILE: rtl/lc3_instruction_step.sv
// Top level of the LC-3 instruction-step core.
// Usage: pulse start with cmd_i while busy is low. A load word (command 0)
// writes one memory word; a step word (command 1) fetches at PC and runs one
// instruction unless the core is halted. Each word gives exactly one result on
// result_o, shown for one cycle with done_o high; the receiver cannot stall it.
// After the accepting cycle, dispatch writes a load word or, for a step, reads
// at PC; fetch and decode follow, then one operand read for LD, LDR and STI,
// two for LDI, then execute and done; a halted step goes from dispatch to done.
// All reads share the single memory port, which takes one read per cycle with
// registered data. busy falls in the cycle after done.
// start_pc is written through cfg_we_i/cfg_wdata_i; the user must write it only
// while idle, and the block does not enforce this. PC takes it at once.
// After reset all MemDepthP memory words are cleared one word per cycle, with
// busy high; configuration writes are taken throughout.
module lc3_instruction_step import lc3_pkg::*; #(
  parameter int unsigned MemDepthP = MemDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  lc3_in_t     cmd_i,
  output logic        done_o,
  output lc3_out_t    result_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);
  lc3_cmd_t  cmd;
  lc3_stat_t stat;

  lc3_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  lc3_dp #(.MemDepthP(MemDepthP)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_word_i   (cmd_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .result_o    (result_o)
  );

  // result registers settle on the edge that ends the execute, load-write or accepting cycle
  assign done_o = cmd.emit;
endmodule

FILE: tb/testbench.sv
// Testbench for lc3_instruction_step: directed and random programs checked against a predictor.
`timescale 1ns / 100ps

module testbench;
  import lc3_pkg::*;

  class lc3_scoreboard;
    logic [15:0] mem [0:65535];
    logic [15:0] regs [0:7];
    logic [15:0] pc;
    logic [2:0]  cc;
    bit          running;
    lc3_out_t    expected_q [$];
    int          n_fail, n_loads, n_steps, n_traps, n_checked;

    function new();
      foreach (mem[i]) mem[i] = '0;
      foreach (regs[i]) regs[i] = '0;
      pc      = StartPcRst;
      cc      = FlagZ;
      running = 1'b1;
    endfunction

    function void set_start_pc(logic [15:0] v);
      pc = v;
    endfunction

    function logic [15:0] widen(logic [15:0] v, int n);
      return 16'($signed(16'(v << (16 - n))) >>> (16 - n));
    endfunction

    // keyboard status word is cleared on any read
    function logic [15:0] fetch_word(logic [15:0] a);
      if (a == KbsrAddr) mem[a] = '0;
      return mem[a];
    endfunction

    function void write_reg(logic [2:0] r, logic [15:0] v);
      regs[r] = v;
      cc = (v == '0) ? FlagZ : (v[15] ? FlagN : FlagP);
    endfunction

    function void note_input(lc3_in_t w);
      lc3_out_t    r;
      logic [15:0] ir, a, b, off9, off6, ret;
      logic [2:0]  dr;
      r = '0;
      if (!w.command) begin
        mem[w.load_address] = w.load_data;
        r.mem_written   = 1'b1;
        r.write_address = w.load_address;
        r.write_data    = w.load_data;
        n_loads++;
      end else if (running) begin
        n_steps++;
        ir = fetch_word(pc);
        pc = pc + 16'd1;
        dr   = ir[11:9];
        a    = regs[ir[8:6]];
        b    = ir[5] ? widen(ir, 5) : regs[ir[2:0]];
        off9 = pc + widen(ir, 9);
        off6 = a + widen(ir, 6);
        r.executed_instruction = ir;
        case (ir[15:12])
          OpBr:  if ((ir[11:9] & cc) != '0) pc = off9;
          OpAdd: write_reg(dr, a + b);
          OpAnd: write_reg(dr, a & b);
          OpNot: write_reg(dr, ~a);
          OpLd:  write_reg(dr, fetch_word(off9));
          OpLdr: write_reg(dr, fetch_word(off6));
          OpLdi: write_reg(dr, fetch_word(fetch_word(off9)));
          OpLea: write_reg(dr, off9);
          OpSt: begin
            r.mem_written = 1'b1; r.write_address = off9; r.write_data = regs[dr];
          end
          OpStr: begin
            r.mem_written = 1'b1; r.write_address = off6; r.write_data = regs[dr];
          end
          OpSti: begin
            r.mem_written = 1'b1; r.write_address = fetch_word(off9); r.write_data = regs[dr];
          end
          OpJsr: begin
            ret = pc;
            pc = ir[11] ? pc + widen(ir, 11) : a;  // JSRR R7 uses the old R7
            regs[7] = ret;
          end
          OpJmp: pc = a;
          OpTrap: begin
            r.trap_taken  = 1'b1;
            r.trap_vector = ir[7:0];
            n_traps++;
            if (ir[7:0] == HaltVector) running = 1'b0;
          end
          default: ;
        endcase
        if (r.mem_written) mem[r.write_address] = r.write_data;
      end
      r.pc_after   = pc;
      r.cond_flags = cc;
      r.halted     = !running;
      expected_q.push_back(r);
    endfunction

    function void cmp(string name, logic [15:0] e, logic [15:0] g);
      if (e !== g) begin
        $error("%s mismatch: expected %h, got %h", name, e, g);
        n_fail++;
      end
    endfunction

    function void check_result(lc3_out_t g);
      lc3_out_t e;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: %h", g);
        n_fail++;
        return;
      end
      e = expected_q.pop_front();
      n_checked++;
      cmp("pc_after", e.pc_after, g.pc_after);
      cmp("cond_flags", 16'(e.cond_flags), 16'(g.cond_flags));
      cmp("halted", 16'(e.halted), 16'(g.halted));
      cmp("executed_instruction", e.executed_instruction, g.executed_instruction);
      cmp("trap_taken", 16'(e.trap_taken), 16'(g.trap_taken));
      cmp("trap_vector", 16'(e.trap_vector), 16'(g.trap_vector));
      cmp("mem_written", 16'(e.mem_written), 16'(g.mem_written));
      cmp("write_address", e.write_address, g.write_address);
      cmp("write_data", e.write_data, g.write_data);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  lc3_in_t     cmd_i = '0;
  logic        done_o;
  lc3_out_t    result_o;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  lc3_scoreboard sb = new();
  int gap_pct;
  int n_cfg;

  always #5 clk_i = ~clk_i;

  lc3_instruction_step i_dut (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .done_o, .result_o, .cfg_we_i, .cfg_wdata_i
  );

  always @(posedge clk_i) if (rst_ni && done_o) sb.check_result(result_o);

  task automatic send(lc3_in_t w);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= w;
    do @(posedge clk_i); while (busy);
    sb.note_input(w);
  endtask

  task automatic load_word(logic [15:0] addr, logic [15:0] data);
    lc3_in_t w;
    w.command = 1'b0; w.load_address = addr; w.load_data = data;
    send(w);
  endtask

  task automatic step_once();
    lc3_in_t w;
    w = lc3_in_t'({1'b1, 32'($urandom)});
    send(w);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_start_pc(logic [15:0] v);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_start_pc(v);
    n_cfg++;
  endtask

  // random instruction word, never a halt trap
  function automatic logic [15:0] rand_instr();
    logic [15:0] ir;
    ir = 16'($urandom);
    if (ir[15:12] == OpTrap && ir[7:0] == HaltVector) ir[7:0] = 8'h20;
    return ir;
  endfunction

  task automatic run_program(logic [15:0] base);
    int n;
    n = $urandom_range(3, 12);
    write_start_pc(base);
    for (int i = 0; i < n; i++) begin
      load_word(base + 16'(i), rand_instr());
      if ($urandom_range(7) == 0)
        load_word(($urandom_range(3) == 0) ? KbsrAddr : 16'($urandom), 16'($urandom));
    end
    for (int i = 0; i < n + $urandom_range(2); i++) step_once();
  endtask

  localparam logic [15:0] Prog [0:17] = '{
    16'h127F, 16'h5460, 16'h96BF, 16'h1843, 16'h0801, 16'h0000, 16'hEB00, 16'h2C08,
    16'hA007, 16'h39F7, 16'hB205, 16'h773F, 16'h6501, 16'h4802, 16'hC0C0, 16'h0000,
    16'hFE00, 16'h41C0
  };

  initial begin
    gap_pct = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_start_pc(StartPcRst);

    // directed: every opcode, taken branch, keyboard clear, JSRR R7, PC wrap
    for (int i = 0; i < 18; i++) load_word(16'h3000 + 16'(i), Prog[i]);
    load_word(16'hFFFF, 16'h8000);
    load_word(16'h0000, 16'hD000);
    load_word(16'h0001, 16'hF023);
    for (int i = 0; i < 19; i++) step_once();
    write_start_pc(KbsrAddr);
    load_word(KbsrAddr, 16'h1234);
    step_once();

    for (int ph = 0; ph < 4; ph++) begin
      gap_pct = (ph == 1) ? 80 : (ph == 3) ? 20 : 0;
      for (int c = 0; c < 17; c++) begin
        run_program((ph == 0 && c == 0) ? 16'h0000 :
                    (ph == 0 && c == 1) ? 16'hFFFF : 16'($urandom));
      end
    end

    // halt last: it can only be undone by reset
    write_start_pc(16'h4000);
    load_word(16'h4000, 16'hF025);
    step_once();
    step_once();
    load_word(16'hFFFF, 16'hA5A5);
    step_once();
    wait_idle();
    repeat (20) @(posedge clk_i);

    $display("covered %0d loads, %0d steps (%0d traps), %0d start_pc writes, %0d results",
             sb.n_loads, sb.n_steps, sb.n_traps, n_cfg, sb.n_checked);
    if (sb.n_fail == 0 && sb.expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule
